/* sv/adaptive_contrast_enhance_core_assert.svh */
// Assertion macros for the adaptive contrast enhancement core.
`ifndef ADAPTIVE_CONTRAST_ENHANCE_CORE_ASSERT_SVH
`define ADAPTIVE_CONTRAST_ENHANCE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Implication checked at every clock edge outside reset.
`define ACE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ace: implication failed");
// Condition that must never hold outside reset.
`define ACE_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("ace: forbidden condition");
`else
`define ACE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ACE_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* sv/ace_pkg.sv */
// Shared constants, types and helper functions for the contrast enhancement core.
package ace_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_WINDOW = 7;
  localparam int ROW_LIMIT  = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(ROW_LIMIT);
  localparam int LINE_W     = $clog2(MAX_WINDOW + 1);
  localparam int STORE_DEPTH = MAX_WINDOW * MAX_WIDTH;
  localparam int STORE_AW   = $clog2(STORE_DEPTH);
  localparam int CFG_DW     = 13;
  localparam int CFG_IW     = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_IW-1:0] CFG_WIDTH  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_HEIGHT = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_WINDOW = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_MAXG   = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_GMEAN  = 3'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;
    logic write;
    logic prod;
    logic tap_start;
    logic var_mul;
    logic var_sub;
    logic k_sq;
    logic srch_a;
    logic srch_b;
    logic srch_c;
    logic mix_a;
    logic mix_b;
    logic mix_c;
    logic div_init;
    logic div_step;
    logic out_load;
  } ace_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic ready_hit;
    logic tap_busy;
    logic search_open;
    logic div_last;
    logic out_free;
  } ace_sts_t;

  // Reflect-101 border rule, result clamped to 0..len-1
  function automatic logic [ROW_W-1:0] reflect101(input logic signed [14:0] x,
                                                  input logic [12:0] len);
    logic signed [15:0] v;
    logic signed [15:0] lm1;
    v   = 16'(x);
    lm1 = $signed({3'b000, len}) - 16'sd1;
    if (v < 0) v = -v;
    if (v > lm1) v = (lm1 <<< 1) - v;
    if (v < 0) v = 16'sd0;
    if (v > lm1) v = lm1;
    return v[ROW_W-1:0];
  endfunction

  // Row modulo the line count, by reciprocal multiply and back-subtraction
  function automatic logic [LINE_W-1:0] line_of(input logic [ROW_W-1:0] row);
    logic [24:0] prod;
    logic [ROW_W-1:0] quo;
    logic [ROW_W-1:0] rem;
    prod = 25'(row) * 25'd4682;
    quo  = ROW_W'(prod[24:15]);
    rem  = row - ROW_W'(quo * ROW_W'(MAX_WINDOW));
    return rem[LINE_W-1:0];
  endfunction

endpackage

/* sv/ace_in_if.sv */
// Input channel: pixel or flush tick with valid/ready handshake.
interface ace_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] pixel;
  modport source (output valid, output mode, output pixel, input ready);
  modport sink (input valid, input mode, input pixel, output ready);
endinterface

/* sv/ace_out_if.sv */
// Result channel: enhanced pixel, gain and frame end with valid/ready handshake.
interface ace_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] enhanced;
  logic [7:0] gain;
  logic       frame_end;
  modport source (output valid, output enhanced, output gain, output frame_end,
                  input ready);
  modport sink (input valid, input enhanced, input gain, input frame_end,
                output ready);
endinterface

/* sv/ace_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ace_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* sv/ace_ctrl.sv */
// Controller state machine sequencing one transaction through the datapath.
module ace_ctrl import ace_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ace_sts_t sts,
  output ace_cmd_t cmd
);
  typedef enum logic [4:0] {
    S_IDLE, S_WRITE, S_PROD, S_CHECK, S_TAPS, S_VAR, S_VSUB, S_KSQ, S_TEST,
    S_SA, S_SB, S_SC, S_MIXA, S_MIXB, S_MIXC, S_DIVI, S_DIV, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Decode commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.latch = in_valid;
        if (in_valid) state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = S_PROD;
      end
      S_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.tap_start = sts.ready_hit;
        state_nxt     = sts.ready_hit ? S_TAPS : S_IDLE;
      end
      S_TAPS: begin
        if (!sts.tap_busy) state_nxt = S_VAR;
      end
      S_VAR: begin
        cmd.var_mul = 1'b1;
        state_nxt   = S_VSUB;
      end
      S_VSUB: begin
        cmd.var_sub = 1'b1;
        state_nxt   = S_KSQ;
      end
      S_KSQ: begin
        cmd.k_sq  = 1'b1;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        state_nxt = sts.search_open ? S_SA : S_MIXA;
      end
      S_SA: begin
        cmd.srch_a = 1'b1;
        state_nxt  = S_SB;
      end
      S_SB: begin
        cmd.srch_b = 1'b1;
        state_nxt  = S_SC;
      end
      S_SC: begin
        cmd.srch_c = 1'b1;
        state_nxt  = S_TEST;
      end
      S_MIXA: begin
        cmd.mix_a = 1'b1;
        state_nxt = S_MIXB;
      end
      S_MIXB: begin
        cmd.mix_b = 1'b1;
        state_nxt = S_MIXC;
      end
      S_MIXC: begin
        cmd.mix_c = 1'b1;
        state_nxt = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.out_load = sts.out_free;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

/* sv/ace_dp.sv */
// Datapath: counters, line store, window sums, gain search, mix and divide.
module ace_dp import ace_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ace_cmd_t          cmd,
  output ace_sts_t          sts,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  logic              in_mode,
  input  logic [7:0]        in_pixel,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_enhanced,
  output logic [7:0]        out_gain,
  output logic              out_frame_end
);
  // Configuration registers
  logic [10:0] width_r;
  logic [12:0] height_r;
  logic [2:0]  window_r;
  logic [7:0]  maxg_r;
  logic [7:0]  gmean_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd640;
      height_r <= 13'd480;
      window_r <= 3'd3;
      maxg_r   <= 8'd120;
      gmean_r  <= 8'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data[10:0];
        CFG_HEIGHT: height_r <= cfg_data[12:0];
        CFG_WINDOW: window_r <= cfg_data[2:0];
        CFG_MAXG:   maxg_r   <= cfg_data[7:0];
        CFG_GMEAN:  gmean_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Effective sizes
  logic [10:0] w_eff;
  logic [12:0] h_eff;
  logic [2:0]  n_eff;
  logic [1:0]  half;
  logic [5:0]  n_sq;

  always_comb begin
    w_eff = width_r;
    if (w_eff == 11'd0) w_eff = 11'd1;
    if (w_eff > 11'(MAX_WIDTH)) w_eff = 11'(MAX_WIDTH);
    h_eff = height_r;
    if (h_eff == 13'd0) h_eff = 13'd1;
    if (h_eff > 13'(ROW_LIMIT)) h_eff = 13'(ROW_LIMIT);
    n_eff = window_r | 3'd1;
    if (n_eff < 3'd3) n_eff = 3'd3;
    half = n_eff[2:1];
    n_sq = 6'(n_eff) * 6'(n_eff);
  end

  // Latched transaction
  logic       mode_r;
  logic [7:0] pix_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= in_mode;
      pix_r  <= in_pixel;
    end
  end

  // Position counters
  logic [COL_W-1:0] in_col_r, out_col_r;
  logic [ROW_W-1:0] in_row_r, out_row_r;
  logic             in_full_r;
  logic             col_last_out, row_last_out;

  assign col_last_out = (11'(out_col_r) + 11'd1 >= w_eff);
  assign row_last_out = (13'(out_row_r) + 13'd1 >= h_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      in_full_r <= 1'b0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (cmd.write && !mode_r && !in_full_r) begin
      if (11'(in_col_r) + 11'd1 >= w_eff) begin
        in_col_r <= '0;
        if (13'(in_row_r) + 13'd1 >= h_eff) begin
          in_row_r  <= '0;
          in_full_r <= 1'b1;
        end else begin
          in_row_r <= in_row_r + 1'b1;
        end
      end else begin
        in_col_r <= in_col_r + 1'b1;
      end
    end else if (cmd.out_load) begin
      if (col_last_out) begin
        out_col_r <= '0;
        if (row_last_out) begin
          out_row_r <= '0;
          in_row_r  <= '0;
          in_col_r  <= '0;
          in_full_r <= 1'b0;
        end else begin
          out_row_r <= out_row_r + 1'b1;
        end
      end else begin
        out_col_r <= out_col_r + 1'b1;
      end
    end
  end

  // Readiness products
  logic [22:0] have_r, kpos_r, lead_r;

  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      have_r <= 23'(in_row_r) * 23'(w_eff) + 23'(in_col_r);
      kpos_r <= 23'(out_row_r) * 23'(w_eff) + 23'(out_col_r);
      lead_r <= 23'(half) * 23'(w_eff) + 23'(half) + 23'd1;
    end
  end

  assign sts.ready_hit = in_full_r || (have_r >= kpos_r + lead_r);

  // Tap issue counters
  logic             issuing_r;
  logic [2:0]       tap_i_r, tap_j_r;
  logic             s1_v_r, s2_v_r, s3_v_r;
  logic             s1_c_r, s2_c_r, s3_c_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [COL_W-1:0] s1_col_r, s2_col_r;
  logic [LINE_W-1:0] s2_line_r;
  logic signed [14:0] x_row, x_col;
  logic [ROW_W-1:0]   col_ref;

  assign x_row = $signed({3'b000, out_row_r}) + $signed({12'd0, tap_i_r})
               - $signed({13'd0, half});
  assign x_col = $signed({5'd0, out_col_r}) + $signed({12'd0, tap_j_r})
               - $signed({13'd0, half});
  assign col_ref = reflect101(x_col, {2'b00, w_eff});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issuing_r <= 1'b0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
    end else begin
      if (cmd.tap_start) begin
        issuing_r <= 1'b1;
        tap_i_r   <= '0;
        tap_j_r   <= '0;
      end else if (issuing_r) begin
        if (tap_j_r == n_eff - 3'd1) begin
          tap_j_r <= '0;
          if (tap_i_r == n_eff - 3'd1) issuing_r <= 1'b0;
          tap_i_r <= tap_i_r + 3'd1;
        end else begin
          tap_j_r <= tap_j_r + 3'd1;
        end
      end
      s1_v_r <= issuing_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // Advance the address pipeline
  always_ff @(posedge clk) begin
    s1_row_r  <= reflect101(x_row, h_eff);
    s1_col_r  <= col_ref[COL_W-1:0];
    s1_c_r    <= (tap_i_r == 3'(half)) && (tap_j_r == 3'(half));
    s2_line_r <= line_of(s1_row_r);
    s2_col_r  <= s1_col_r;
    s2_c_r    <= s1_c_r;
    s3_c_r    <= s2_c_r;
  end

  assign sts.tap_busy = issuing_r || s1_v_r || s2_v_r || s3_v_r;

  // Line store
  logic [STORE_AW-1:0] waddr, raddr;
  logic [7:0]          rdata;

  assign waddr = STORE_AW'({line_of(in_row_r), in_col_r});
  assign raddr = STORE_AW'({s2_line_r, s2_col_r});

  ace_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (cmd.write && !mode_r && !in_full_r),
    .waddr (waddr),
    .wdata (pix_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Accumulate window sums
  logic [13:0] sum_r;
  logic [21:0] sumsq_r;
  logic [7:0]  ctr_r;

  always_ff @(posedge clk) begin
    if (cmd.tap_start) begin
      sum_r   <= '0;
      sumsq_r <= '0;
    end else if (s3_v_r) begin
      sum_r   <= sum_r + 14'(rdata);
      sumsq_r <= sumsq_r + 22'(16'(rdata) * 16'(rdata));
      if (s3_c_r) ctr_r <= rdata;
    end
  end

  // Variance and gain bound
  logic [27:0] nq_r, ss_r, var_r;
  logic [13:0] gmn_r;
  logic [17:0] kk_r;
  logic [37:0] lim_r;
  logic [7:0]  lo_r, hi_r, mid_r;
  logic [17:0] tt_r;
  logic [31:0] pl_r, ph_r;
  logic [8:0]  mid_sum;
  logic [7:0]  mid;
  logic [8:0]  tval;
  logic [45:0] tvprod;
  logic        var_zero;

  assign mid_sum  = 9'(lo_r) + 9'(hi_r) + 9'd1;
  assign mid      = mid_sum[8:1];
  assign tval     = {mid, 1'b0} - 9'd1;
  assign tvprod   = (46'(ph_r) << 14) + 46'(pl_r);
  assign var_zero = (var_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.var_mul) begin
      nq_r  <= 28'(n_sq) * 28'(sumsq_r);
      ss_r  <= 28'(sum_r) * 28'(sum_r);
      gmn_r <= 14'(gmean_r) * 14'(n_sq);
    end
    if (cmd.var_sub) begin
      var_r <= nq_r - ss_r;
      kk_r  <= {gmn_r, 4'b0000};
    end
    if (cmd.k_sq) begin
      lim_r <= (38'(kk_r) * 38'(kk_r)) << 2;
      lo_r  <= '0;
      hi_r  <= maxg_r;
    end
    if (cmd.srch_a) begin
      mid_r <= mid;
      tt_r  <= 18'(tval) * 18'(tval);
    end
    if (cmd.srch_b) begin
      pl_r <= 32'(tt_r) * 32'(var_r[13:0]);
      ph_r <= 32'(tt_r) * 32'(var_r[27:14]);
    end
    if (cmd.srch_c) begin
      if (tvprod <= 46'(lim_r)) lo_r <= mid_r;
      else hi_r <= mid_r - 8'd1;
    end
  end

  assign sts.search_open = !var_zero && (lo_r < hi_r);

  // Mix centre pixel with mean
  logic [7:0]         g_r;
  logic [13:0]        np_r;
  logic signed [14:0] diff_r;
  logic signed [24:0] num_r;
  logic signed [24:0] s16, gs, ds;

  assign s16 = $signed({7'd0, sum_r, 4'b0000});
  assign gs  = $signed({17'd0, g_r});
  assign ds  = {{10{diff_r[14]}}, diff_r};

  always_ff @(posedge clk) begin
    if (cmd.mix_a) begin
      np_r <= 14'(n_sq) * 14'(ctr_r);
      g_r  <= var_zero ? maxg_r : lo_r;
    end
    if (cmd.mix_b) begin
      diff_r <= $signed({1'b0, np_r}) - $signed({1'b0, sum_r});
    end
    if (cmd.mix_c) begin
      num_r <= s16 + gs * ds;
    end
  end

  // Round and divide by the window area, one quotient bit a step
  logic [24:0] rnd;
  logic [19:0] yval;
  logic        sat;
  logic [13:0] rem_r;
  logic [7:0]  quo_r;
  logic        sat_r;
  logic [2:0]  dcnt_r;
  logic [13:0] dsub;

  assign rnd  = 25'(num_r) + 25'({n_sq, 3'b000});
  assign yval = rnd[23:4];
  assign sat  = (yval >= 20'({n_sq, 8'h00}));
  assign dsub = 14'(n_sq) << dcnt_r;

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      sat_r  <= (num_r > 0) && sat;
      rem_r  <= ((num_r > 0) && !sat) ? yval[13:0] : 14'd0;
      quo_r  <= '0;
      dcnt_r <= 3'd7;
    end else if (cmd.div_step) begin
      if (rem_r >= dsub) begin
        rem_r         <= rem_r - dsub;
        quo_r[dcnt_r] <= 1'b1;
      end
      dcnt_r <= dcnt_r - 3'd1;
    end
  end

  assign sts.div_last = (dcnt_r == 3'd0);

  // Output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_enhanced  <= sat_r ? 8'hFF : quo_r;
      out_gain      <= g_r;
      out_frame_end <= col_last_out && row_last_out;
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.out_free = !out_valid_r || out_ready;
endmodule

/* sv/adaptive_contrast_enhance_core.sv */
// Adaptive contrast enhancement core: top level.
// Usage: feed one transaction per pixel on in_ch (mode 0 carries a pixel in
// raster order, mode 1 is a flush tick); results leave on out_ch. Configuration
// registers are written through cfg_we/cfg_index/cfg_data; the user must write
// them only while the core is idle, which the core itself does not enforce.
// Each transaction is handled on its own: one that gives no result only stores
// its pixel and checks readiness; one that gives a result also reads the line
// store once per tap of the n x n window (n the window side) and runs a gain
// search of at most 8 steps, each one compare through a pair of multipliers.
// Output k of a frame appears on the transaction that stores pixel
// k + h*W + h (h = (n-1)/2); flush ticks drain the last rows.
// Reset is synchronous: position counters and control clear, configuration returns to
// its defaults; the line store is not cleared.
// A result sits in an output register; while the receiver stalls the next
// transaction is still accepted and processed up to the point of delivery.
`include "adaptive_contrast_enhance_core_assert.svh"
module adaptive_contrast_enhance_core import ace_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  ace_in_if.sink            in_ch,
  ace_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);
  ace_cmd_t cmd;
  ace_sts_t sts;

  ace_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ace_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_mode       (in_ch.mode),
    .in_pixel      (in_ch.pixel),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_enhanced  (out_ch.enhanced),
    .out_gain      (out_ch.gain),
    .out_frame_end (out_ch.frame_end)
  );

  // Check controller and datapath agree
  `ACE_ASSERT_IMPLY(a_load_free, clk, rst_n, cmd.out_load, sts.out_free)
  `ACE_ASSERT_IMPLY(a_start_idle, clk, rst_n, cmd.tap_start, !sts.tap_busy)
  `ACE_ASSERT_NEVER(a_accept_busy, clk, rst_n, in_ch.valid && in_ch.ready && sts.tap_busy)
endmodule
